// File: hw/rtl/dtr_pkg.sv
// Shared types, constants and codes for the best-ratio subset selector.
`default_nettype none
package dtr_pkg;

   localparam int MAX_ITEMS  = 1024;
   localparam int IDX_W      = $clog2(MAX_ITEMS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int VALUE_W    = 20;
   localparam int KEY_W      = 64;
   localparam int RATIO_W    = 43;
   localparam int FRAC_W     = 16;
   localparam int SUM_W      = 31;
   localparam int SCALED_W   = SUM_W + 7;
   localparam int NUM_W      = SCALED_W + FRAC_W;
   localparam int MAX_ROUNDS = 32;
   localparam int ROUND_W    = 6;
   localparam int DROP_W     = 11;
   localparam int ERR_W      = 2;
   localparam int LO_W       = 22;
   localparam int HI_W       = RATIO_W - LO_W;

   localparam logic [RATIO_W-1:0] START_RATIO = RATIO_W'(100) << FRAC_W;
   localparam logic [RATIO_W-1:0] RATIO_MAX   = {RATIO_W{1'b1}};

   localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
   localparam logic [ERR_W-1:0] ERR_NONE     = 2'd1;
   localparam logic [ERR_W-1:0] ERR_ZERO_WT  = 2'd2;
   localparam logic [ERR_W-1:0] ERR_TOO_MANY = 2'd3;

   typedef struct packed {
      logic [VALUE_W-1:0] score;
      logic [VALUE_W-1:0] weight;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [RATIO_W-1:0] best_ratio;
      logic [ERR_W-1:0]   error;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [IDX_W-1:0]   idx;
      logic [VALUE_W-1:0] score;
      logic [VALUE_W-1:0] weight;
   } item_type;

   typedef struct packed {
      logic flush;
      logic shift;
   } chain_ctl_type;

endpackage
`default_nettype wire

// File: hw/rtl/dinkelbach_topk_ratio_max.sv
// Top level: item store, key pipeline, sorting chain, divider and round control.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | dtr_pkg::req_type
//  rsp     | out       | rsp_valid/rsp_stall | dtr_pkg::rsp_type
//  csr     | in        | csr_we              | drop_count (11 bits)
//
// Items load one a cycle into the store. The last item starts the solve; each
// round is a check, the n items fed through the key pipeline, a settle while
// the cell chain orders them, the k kept items shifted out of the head, a divide
// check and a divide wait, for at most 32 rounds plus a final check. req_stall
// is high for the whole solve.
// Reset is synchronous; the store is not cleared. The result waits in an
// output register while rsp_stall is high.
`default_nettype none
module dinkelbach_topk_ratio_max (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  dtr_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output dtr_pkg::rsp_type              rsp_data,
   input  wire                           csr_we,
   input  wire [dtr_pkg::DROP_W-1:0]     csr_wdata
);

   localparam logic [2:0] ST_LOAD   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_FEED   = 3'd2;
   localparam logic [2:0] ST_SETTLE = 3'd3;
   localparam logic [2:0] ST_SUM    = 3'd4;
   localparam logic [2:0] ST_DIVCHK = 3'd5;
   localparam logic [2:0] ST_DIVW   = 3'd6;
   localparam logic [2:0] ST_OUT    = 3'd7;

   localparam int MEM_W = 2 * dtr_pkg::VALUE_W;

   logic [2:0]                    state_ff, state_in;
   logic [dtr_pkg::DROP_W-1:0]    drop_ff, drop_in;
   logic [dtr_pkg::CNT_W-1:0]     count_ff, count_in;
   logic                          ovf_ff, ovf_in;
   logic [dtr_pkg::CNT_W-1:0]     n_ff, n_in;
   logic [dtr_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [dtr_pkg::IDX_W-1:0]     rd_ff, rd_in;
   logic [dtr_pkg::RATIO_W-1:0]   used_ff, used_in;
   logic [dtr_pkg::RATIO_W-1:0]   next_ff, next_in;
   logic [dtr_pkg::ROUND_W-1:0]   round_ff, round_in;
   logic [dtr_pkg::SUM_W-1:0]     ssum_ff, ssum_in;
   logic [dtr_pkg::SUM_W-1:0]     wsum_ff, wsum_in;
   logic [dtr_pkg::ERR_W-1:0]     err_ff, err_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   dtr_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   logic                          req_xfer, rsp_xfer;
   logic [dtr_pkg::CNT_W-1:0]     n_new, k_cnt;
   logic                          ovf_new;
   logic                          rd_en;
   logic                          div_start, div_done;
   logic [dtr_pkg::NUM_W-1:0]     div_num, div_q;
   dtr_pkg::chain_ctl_type        chain_ctl;
   logic                          head_valid;
   dtr_pkg::item_type             head_item;

   // item store
   logic [MEM_W-1:0]              mem [dtr_pkg::MAX_ITEMS];
   logic [MEM_W-1:0]              mem_q_ff;

   // key pipeline registers
   logic                          s1_v_ff;
   logic [dtr_pkg::IDX_W-1:0]     s1_idx_ff;
   logic                          s2_v_ff;
   logic [dtr_pkg::IDX_W-1:0]     s2_idx_ff;
   logic [dtr_pkg::VALUE_W-1:0]   s2_score_ff, s2_weight_ff;
   logic [dtr_pkg::LO_W+dtr_pkg::VALUE_W-1:0] s2_lo_ff;
   logic [dtr_pkg::HI_W+dtr_pkg::VALUE_W-1:0] s2_hi_ff;
   logic [dtr_pkg::RATIO_W-1:0]   s2_a_ff;
   logic                          s3_v_ff;
   dtr_pkg::item_type             s3_item_ff, s3_item_in;

   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign req_stall = state_ff != ST_LOAD;

   always_comb begin
      ovf_new = ovf_ff || (count_ff == dtr_pkg::CNT_W'(dtr_pkg::MAX_ITEMS));
      n_new   = ovf_new ? count_ff : count_ff + 1'b1;
      k_cnt   = n_ff - dtr_pkg::CNT_W'(drop_ff);
      div_num = {dtr_pkg::SCALED_W'(ssum_ff) * dtr_pkg::SCALED_W'(100),
                 {dtr_pkg::FRAC_W{1'b0}}};
   end

   // store write on load, registered read while feeding
   assign rd_en = state_ff == ST_FEED;
   always_ff @(posedge clock) begin
      if (req_xfer && !ovf_new) begin
         mem[count_ff[dtr_pkg::IDX_W-1:0]] <= {req_data.score, req_data.weight};
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_ff];
      end
   end

   // key = (100*score << 16) - ratio*weight, split multiply
   always_comb begin
      s3_item_in.key = dtr_pkg::KEY_W'(s2_a_ff)
                     - (dtr_pkg::KEY_W'(s2_hi_ff) << dtr_pkg::LO_W)
                     - dtr_pkg::KEY_W'(s2_lo_ff);
      s3_item_in.idx    = s2_idx_ff;
      s3_item_in.score  = s2_score_ff;
      s3_item_in.weight = s2_weight_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= rd_en;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
      s1_idx_ff    <= rd_ff;
      s2_idx_ff    <= s1_idx_ff;
      s2_score_ff  <= mem_q_ff[MEM_W-1:dtr_pkg::VALUE_W];
      s2_weight_ff <= mem_q_ff[dtr_pkg::VALUE_W-1:0];
      s2_lo_ff     <= used_ff[dtr_pkg::LO_W-1:0] * mem_q_ff[dtr_pkg::VALUE_W-1:0];
      s2_hi_ff     <= used_ff[dtr_pkg::RATIO_W-1:dtr_pkg::LO_W]
                      * mem_q_ff[dtr_pkg::VALUE_W-1:0];
      s2_a_ff      <= dtr_pkg::RATIO_W'({dtr_pkg::SCALED_W'(mem_q_ff[MEM_W-1:dtr_pkg::VALUE_W])
                       * dtr_pkg::SCALED_W'(100), {dtr_pkg::FRAC_W{1'b0}}});
      s3_item_ff   <= s3_item_in;
   end

   dtr_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctl        (chain_ctl),
      .in_valid   (s3_v_ff),
      .in_item    (s3_item_ff),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   dtr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (wsum_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   // round control
   always_comb begin
      state_in        = state_ff;
      drop_in         = csr_we ? csr_wdata : drop_ff;
      count_in        = count_ff;
      ovf_in          = ovf_ff;
      n_in            = n_ff;
      cnt_in          = cnt_ff;
      rd_in           = rd_ff;
      used_in         = used_ff;
      next_in         = next_ff;
      round_in        = round_ff;
      ssum_in         = ssum_ff;
      wsum_in         = wsum_ff;
      err_in          = err_ff;
      rsp_valid_in    = rsp_xfer ? 1'b0 : rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      chain_ctl.flush = 1'b0;
      chain_ctl.shift = 1'b0;
      div_start       = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               count_in = n_new;
               ovf_in   = ovf_new;
               if (req_data.last) begin
                  n_in     = n_new;
                  used_in  = '0;
                  next_in  = dtr_pkg::START_RATIO;
                  round_in = '0;
                  count_in = '0;
                  ovf_in   = 1'b0;
                  if (ovf_new) begin
                     err_in   = dtr_pkg::ERR_TOO_MANY;
                     state_in = ST_OUT;
                  end else if (n_new <= dtr_pkg::CNT_W'(drop_ff)) begin
                     err_in   = dtr_pkg::ERR_NONE;
                     state_in = ST_OUT;
                  end else begin
                     err_in   = dtr_pkg::ERR_OK;
                     state_in = ST_CHECK;
                  end
               end
            end
         end
         ST_CHECK: begin
            chain_ctl.flush = 1'b1;
            if (next_ff == used_ff ||
                round_ff == dtr_pkg::ROUND_W'(dtr_pkg::MAX_ROUNDS)) begin
               state_in = ST_OUT;
            end else begin
               used_in  = next_ff;
               round_in = round_ff + 1'b1;
               rd_in    = '0;
               state_in = ST_FEED;
            end
         end
         ST_FEED: begin
            rd_in = rd_ff + 1'b1;
            if (rd_ff == dtr_pkg::IDX_W'(n_ff - 1'b1)) begin
               cnt_in   = '0;
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == n_ff + dtr_pkg::CNT_W'(6)) begin
               cnt_in   = '0;
               ssum_in  = '0;
               wsum_in  = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            chain_ctl.shift = 1'b1;
            ssum_in = ssum_ff + dtr_pkg::SUM_W'(head_item.score);
            wsum_in = wsum_ff + dtr_pkg::SUM_W'(head_item.weight);
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == k_cnt - 1'b1) begin
               state_in = ST_DIVCHK;
            end
         end
         ST_DIVCHK: begin
            if (wsum_ff == '0) begin
               err_in   = dtr_pkg::ERR_ZERO_WT;
               state_in = ST_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVW;
            end
         end
         ST_DIVW: begin
            if (div_done) begin
               next_in  = (div_q > dtr_pkg::NUM_W'(dtr_pkg::RATIO_MAX)) ?
                          dtr_pkg::RATIO_MAX : div_q[dtr_pkg::RATIO_W-1:0];
               state_in = ST_CHECK;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_xfer) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.error      = err_ff;
               rsp_data_in.best_ratio = (err_ff == dtr_pkg::ERR_OK) ? used_ff : '0;
               state_in               = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         drop_ff      <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         drop_ff      <= drop_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      cnt_ff      <= cnt_in;
      rd_ff       <= rd_in;
      used_ff     <= used_in;
      next_ff     <= next_in;
      ssum_ff     <= ssum_in;
      wsum_ff     <= wsum_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // an error result never carries a ratio
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.error != dtr_pkg::ERR_OK) |->
      rsp_data_ff.best_ratio == '0)
      else $error("error result with nonzero ratio");

   // round cap holds
   a_round_cap: assert property (@(posedge clock) disable iff (reset)
      round_ff <= dtr_pkg::ROUND_W'(dtr_pkg::MAX_ROUNDS))
      else $error("round count past cap");

   // the divider never starts on a zero kept weight
   a_div_den: assert property (@(posedge clock) disable iff (reset)
      div_start |-> wsum_ff != '0)
      else $error("divide by zero started");

   // the head of the chain is valid during every summing cycle
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM |-> head_valid)
      else $error("summing an empty cell");

endmodule
`default_nettype wire

// File: hw/rtl/dtr_cell.sv
// One sorting cell: holds one item, passes the loser of each compare down the chain.
`default_nettype none
module dtr_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  dtr_pkg::chain_ctl_type ctl,
   input  wire                    ins_valid,
   input  dtr_pkg::item_type      ins_item,
   input  wire                    below_valid,
   input  dtr_pkg::item_type      below_item,
   output logic                   held_valid,
   output dtr_pkg::item_type      held_item,
   output logic                   pass_valid,
   output dtr_pkg::item_type      pass_item
);

   logic              held_valid_ff, held_valid_in;
   dtr_pkg::item_type held_item_ff, held_item_in;
   logic              pass_valid_ff, pass_valid_in;
   dtr_pkg::item_type pass_item_ff, pass_item_in;
   logic              wins;

   // incoming beats held on larger key, then on earlier load position
   always_comb begin
      wins = ins_valid && (!held_valid_ff ||
             ($signed(ins_item.key) > $signed(held_item_ff.key)) ||
             ((ins_item.key == held_item_ff.key) && (ins_item.idx < held_item_ff.idx)));
   end

   always_comb begin
      held_valid_in = held_valid_ff;
      held_item_in  = held_item_ff;
      pass_valid_in = 1'b0;
      pass_item_in  = ins_item;
      if (ctl.flush) begin
         held_valid_in = 1'b0;
      end else if (ctl.shift) begin
         held_valid_in = below_valid;
         held_item_in  = below_item;
      end else if (ins_valid) begin
         if (wins) begin
            held_valid_in = 1'b1;
            held_item_in  = ins_item;
            pass_valid_in = held_valid_ff;
            pass_item_in  = held_item_ff;
         end else begin
            pass_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         pass_valid_ff <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         pass_valid_ff <= pass_valid_in;
      end
      held_item_ff <= held_item_in;
      pass_item_ff <= pass_item_in;
   end

   assign held_valid = held_valid_ff;
   assign held_item  = held_item_ff;
   assign pass_valid = pass_valid_ff;
   assign pass_item  = pass_item_ff;

endmodule
`default_nettype wire

// File: hw/rtl/dtr_chain.sv
// Row of sorting cells: insert one item a cycle, then shift out from the head.
`default_nettype none
module dtr_chain (
   input  wire                    clock,
   input  wire                    reset,
   input  dtr_pkg::chain_ctl_type ctl,
   input  wire                    in_valid,
   input  dtr_pkg::item_type      in_item,
   output logic                   head_valid,
   output dtr_pkg::item_type      head_item
);

   logic              pass_v [dtr_pkg::MAX_ITEMS+1];
   dtr_pkg::item_type pass_i [dtr_pkg::MAX_ITEMS+1];
   logic              held_v [dtr_pkg::MAX_ITEMS+1];
   dtr_pkg::item_type held_i [dtr_pkg::MAX_ITEMS+1];

   assign pass_v[0] = in_valid;
   assign pass_i[0] = in_item;
   assign held_v[dtr_pkg::MAX_ITEMS] = 1'b0;
   assign held_i[dtr_pkg::MAX_ITEMS] = '0;

   for (genvar g = 0; g < dtr_pkg::MAX_ITEMS; g++) begin : g_cell
      dtr_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .ins_valid   (pass_v[g]),
         .ins_item    (pass_i[g]),
         .below_valid (held_v[g+1]),
         .below_item  (held_i[g+1]),
         .held_valid  (held_v[g]),
         .held_item   (held_i[g]),
         .pass_valid  (pass_v[g+1]),
         .pass_item   (pass_i[g+1])
      );
   end

   assign head_valid = held_v[0];
   assign head_item  = held_i[0];

endmodule
`default_nettype wire

// File: hw/rtl/dtr_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module dtr_div (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   input  wire [dtr_pkg::NUM_W-1:0]       num,
   input  wire [dtr_pkg::SUM_W-1:0]       den,
   output logic                           done,
   output logic [dtr_pkg::NUM_W-1:0]      quot
);

   localparam int STEP_W = $clog2(dtr_pkg::NUM_W);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic [dtr_pkg::NUM_W-1:0]    num_ff, num_in;
   logic [dtr_pkg::NUM_W-1:0]    quot_ff, quot_in;
   logic [dtr_pkg::SUM_W-1:0]    den_ff, den_in;
   logic [dtr_pkg::SUM_W-1:0]    rem_ff, rem_in;
   logic [dtr_pkg::SUM_W:0]      trial;
   logic                         fits;

   always_comb begin
      trial   = {rem_ff, num_ff[dtr_pkg::NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in  = num_ff << 1;
         quot_in = {quot_ff[dtr_pkg::NUM_W-2:0], fits};
         rem_in  = fits ? dtr_pkg::SUM_W'(trial - {1'b0, den_ff})
                        : trial[dtr_pkg::SUM_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(dtr_pkg::NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

// File: sim/dinkelbach_topk_ratio_max_tb.sv
// Testbench for the best-ratio subset selector: random and directed sets vs a predictor.
`timescale 1ns / 100ps
module dinkelbach_topk_ratio_max_tb;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int LONG_HOLD   = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   dtr_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   dtr_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [dtr_pkg::DROP_W-1:0] csr_wdata = '0;

   dinkelbach_topk_ratio_max dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state
   bit [dtr_pkg::VALUE_W-1:0] score_mem [dtr_pkg::MAX_ITEMS];
   bit [dtr_pkg::VALUE_W-1:0] weight_mem [dtr_pkg::MAX_ITEMS];
   longint key_mem [dtr_pkg::MAX_ITEMS];
   int rank_mem [dtr_pkg::MAX_ITEMS];
   int loaded = 0;
   bit spilled = 0;
   int drop_setting = 0;

   dtr_pkg::req_type pending_items[$];
   dtr_pkg::rsp_type ratio_expect[$];
   int errors = 0;
   int cycles = 0;
   bit calm = 0;
   bit sent = 0;
   bit long_hold_req = 0;
   int gap_left = 0;
   int hold_left = 0;
   int stall_left = 0;

   // stable descending order of keys, earlier item first on ties
   function automatic void rank_items(int n);
      int i, j, v;
      for (i = 0; i < n; i++) rank_mem[i] = i;
      for (i = 1; i < n; i++) begin
         v = rank_mem[i];
         j = i;
         while (j > 0 && key_mem[v] > key_mem[rank_mem[j-1]]) begin
            rank_mem[j] = rank_mem[j-1];
            j--;
         end
         rank_mem[j] = v;
      end
   endfunction

   // Dinkelbach rounds on the loaded set; returns error code
   function automatic logic [dtr_pkg::ERR_W-1:0] solve_ratio(int n, int k,
                                   output logic [dtr_pkg::RATIO_W-1:0] best);
      bit [63:0] used, nxt, ss, ws, q, kv;
      int rounds, i;
      used = 0;
      nxt = 64'(dtr_pkg::START_RATIO);
      rounds = 0;
      while (nxt != used && rounds < dtr_pkg::MAX_ROUNDS) begin
         used = nxt;
         for (i = 0; i < n; i++) begin
            kv = ((64'(score_mem[i]) * 64'd100) << dtr_pkg::FRAC_W)
                 - used * 64'(weight_mem[i]);
            key_mem[i] = longint'(kv);
         end
         rank_items(n);
         ss = 0;
         ws = 0;
         for (i = 0; i < k; i++) begin
            ss += 64'(score_mem[rank_mem[i]]);
            ws += 64'(weight_mem[rank_mem[i]]);
         end
         ss &= 64'h7FFF_FFFF;
         ws &= 64'h7FFF_FFFF;
         rounds++;
         if (ws == 0) begin
            best = '0;
            return dtr_pkg::ERR_ZERO_WT;
         end
         q = ((ss * 64'd100) << dtr_pkg::FRAC_W) / ws;
         nxt = (q > 64'(dtr_pkg::RATIO_MAX)) ? 64'(dtr_pkg::RATIO_MAX) : q;
      end
      best = used[dtr_pkg::RATIO_W-1:0];
      return dtr_pkg::ERR_OK;
   endfunction

   // one accepted item: load, and on last predict the result
   function automatic void load_item(dtr_pkg::req_type it);
      dtr_pkg::rsp_type r;
      logic [dtr_pkg::RATIO_W-1:0] best;
      if (loaded < dtr_pkg::MAX_ITEMS) begin
         score_mem[loaded] = it.score;
         weight_mem[loaded] = it.weight;
         loaded++;
      end else begin
         spilled = 1;
      end
      if (it.last) begin
         best = '0;
         if (spilled) r.error = dtr_pkg::ERR_TOO_MANY;
         else if (drop_setting >= loaded) r.error = dtr_pkg::ERR_NONE;
         else r.error = solve_ratio(loaded, loaded - drop_setting, best);
         r.best_ratio = (r.error == dtr_pkg::ERR_OK) ? best : '0;
         ratio_expect.push_back(r);
         loaded = 0;
         spilled = 0;
      end
   endfunction

   // request transfers and cycle limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
      sent = 0;
      if (!reset && req_valid && !req_stall) begin
         load_item(req_data);
         sent = 1;
      end
   end

   // sender: offers queued items with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !sent) begin
         req_valid <= 1'b1;
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         req_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
         if (!calm && $urandom_range(0, 9) == 0) begin
            gap_left <= $urandom_range(0, 11);
            req_valid <= 1'b0;
         end else begin
            req_data <= pending_items.pop_front();
            req_valid <= 1'b1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver stall: random bursts plus one long hold on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (long_hold_req) begin
         long_hold_req = 0;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 11);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // result checker
   always @(posedge clock) begin
      dtr_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (ratio_expect.size() == 0) begin
            $error("unexpected result transfer: best_ratio %0d error %0d",
                   rsp_data.best_ratio, rsp_data.error);
            errors++;
         end else begin
            want = ratio_expect.pop_front();
            if (rsp_data.best_ratio !== want.best_ratio) begin
               $error("best_ratio expected %0d actual %0d", want.best_ratio,
                      rsp_data.best_ratio);
               errors++;
            end
            if (rsp_data.error !== want.error) begin
               $error("error expected %0d actual %0d", want.error, rsp_data.error);
               errors++;
            end
         end
      end
   end

   task automatic push_item(int s, int w, bit lst);
      dtr_pkg::req_type it;
      it.score = dtr_pkg::VALUE_W'(s);
      it.weight = dtr_pkg::VALUE_W'(w);
      it.last = lst;
      pending_items.push_back(it);
   endtask

   // random set; style picks the value spread
   task automatic push_set(int n);
      int i, style, s, w;
      style = $urandom_range(0, 5);
      for (i = 0; i < n; i++) begin
         case (style)
            0: begin
               s = $urandom_range(0, 15);
               w = $urandom_range(0, 15);
            end
            1: begin
               s = $urandom;
               w = $urandom_range(0, 3) == 0 ? 0 : $urandom;
            end
            2: begin
               s = $urandom_range(0, 3);
               w = 0;
            end
            3: begin
               s = $urandom_range(0, 3) == 0 ? 20'hFFFFF : $urandom_range(0, 50);
               w = $urandom_range(1, 4);
            end
            default: begin
               s = $urandom;
               w = $urandom;
            end
         endcase
         push_item(s, w, i == n - 1);
      end
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || ratio_expect.size() > 0 || req_valid)
         @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_drop(int d);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= dtr_pkg::DROP_W'(d);
      drop_setting = d;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int drops[7] = '{0, 1, 3, 1024, 2, 5, 0};
      int p, budget, n;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, zero weight, ties, single item, overflow
      write_drop(0);
      push_item(20'hFFFFF, 20'hFFFFF, 1);
      push_item(20'hFFFFF, 1, 1);
      push_item(0, 20'hFFFFF, 1);
      push_item(5, 0, 0);
      push_item(7, 0, 1);
      push_item(3, 2, 0);
      push_item(3, 2, 0);
      push_item(6, 4, 1);
      drain();
      write_drop(1);
      push_item(9, 3, 1);
      push_item(20'hFFFFF, 20'hFFFFF, 0);
      push_item(1, 20'hFFFFF, 0);
      push_item(0, 0, 1);
      push_item(4, 0, 0);
      push_item(8, 20'hFFFFF, 1);
      for (int i = 0; i < dtr_pkg::MAX_ITEMS + 1; i++)
         push_item($urandom, $urandom, i == dtr_pkg::MAX_ITEMS);
      drain();

      // random phases at several drop settings
      budget = 310;
      for (p = 0; p < 7; p++) begin
         drain();
         write_drop(drops[p]);
         if (p == 6) calm = 1;
         if (p == 1) long_hold_req = 1;
         for (int b = 0; b < budget / 7; b += n) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                            : $urandom_range(1, 16);
            push_set(n);
         end
      end

      drain();
      repeat (200) @(negedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

// File: files.f
hw/rtl/dtr_pkg.sv
hw/rtl/dtr_cell.sv
hw/rtl/dtr_chain.sv
hw/rtl/dtr_div.sv
hw/rtl/dinkelbach_topk_ratio_max.sv
sim/dinkelbach_topk_ratio_max_tb.sv
